// ===== hdl/nbef_pkg.sv =====
// shared types, constants and step table for the notch biquad filter
`timescale 1ns / 1ps

package nbef_pkg;

   // field and register widths
   localparam int SAMPLE_W   = 32;
   localparam int COEFF_W    = 32;
   localparam int DEN0_W     = 31;
   localparam int RECIP_W    = 16;
   localparam int REST_W     = 31;
   localparam int REM_W      = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // datapath widths: one 33x33 signed multiplier works on 32-bit chunks
   localparam int CHUNK_W = 32;
   localparam int MUL_W   = CHUNK_W + 1;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int P_W     = 2 * COEFF_W;
   localparam int K_W     = REST_W + RECIP_W;
   localparam int ACC_W   = 72;
   localparam int T1_W    = 96;
   localparam int TMP_W   = 128;
   localparam int FRAC_W  = 30;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_C0    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_C1    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_C2    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_C0    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_C1    = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_C2    = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_Q30 = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_REST = CSR_IDX_W'(7);

   // register reset values (unity pass-through)
   localparam logic [COEFF_W-1:0] NUM_C0_RST = COEFF_W'(32768);
   localparam logic [DEN0_W-1:0]  DEN_C0_RST = DEN0_W'(32768);
   localparam logic [RECIP_W-1:0] RECIP_RST  = RECIP_W'(32768);

   // multiplier operand selects
   typedef enum logic [3:0] {
      A_ZERO, A_X, A_PI0, A_PI1, A_PO0, A_PO1, A_PR0, A_PR1,
      A_PLO, A_PHI, A_ACC0, A_ACC1, A_ACC2, A_Y, A_REST
   } a_sel_type;

   typedef enum logic [3:0] {
      B_ZERO, B_C0, B_C1, B_C2, B_D0, B_D1, B_D2, B_RECIP, B_KLO, B_KHI
   } b_sel_type;

   // write-stage operations
   typedef enum logic [3:0] {
      OP_NOP, OP_ACC_SET, OP_ACC_ADD, OP_ACC_SUB, OP_P_SET, OP_K_SET,
      OP_TMP_SET, OP_TMP_ADD, OP_T1_SET, OP_T1_ADD, OP_ACC_SUB_TMP,
      OP_T1_ADD_TMP, OP_RND_MAG, OP_RND_SAT
   } op_type;

   // product placement in chunks
   typedef enum logic [1:0] {SH_0, SH_32, SH_64, SH_96} shift_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      op_type    op;
      shift_type shift;
   } uop_type;

   typedef struct packed {
      logic    load;
      logic    finish;
      uop_type uop;
   } dp_cmd_type;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_type;

   localparam int NUM_STEPS = 30;
   localparam int STEP_W    = $clog2(NUM_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

   localparam uop_type UOP_NOP = '{a_sel: A_ZERO, b_sel: B_ZERO, op: OP_NOP, shift: SH_0};

   function automatic uop_type mk_uop(input a_sel_type a, input b_sel_type b,
                                      input op_type o, input shift_type s);
      return '{a_sel: a, b_sel: b, op: o, shift: s};
   endfunction

   // step table; a product is registered and then written in a separate write
   // stage, so no step reads a register in the step right after the one that writes it
   function automatic uop_type ucode(input logic [STEP_W-1:0] step);
      uop_type u;
      unique case (int'(step))
         // numerator and output history terms
         0:  u = mk_uop(A_X,    B_C0,    OP_ACC_SET,     SH_0);
         1:  u = mk_uop(A_PI0,  B_C1,    OP_ACC_ADD,     SH_0);
         2:  u = mk_uop(A_PI1,  B_C2,    OP_ACC_ADD,     SH_0);
         3:  u = mk_uop(A_PO0,  B_D1,    OP_ACC_SUB,     SH_0);
         4:  u = mk_uop(A_PO1,  B_D2,    OP_ACC_SUB,     SH_0);
         // remainder feedback of the newer sample
         5:  u = mk_uop(A_PR0,  B_D1,    OP_P_SET,       SH_0);
         6:  u = mk_uop(A_REST, B_RECIP, OP_K_SET,       SH_0);
         7:  u = mk_uop(A_PLO,  B_RECIP, OP_TMP_SET,     SH_0);
         8:  u = mk_uop(A_PHI,  B_RECIP, OP_TMP_ADD,     SH_32);
         // remainder feedback of the older sample
         9:  u = mk_uop(A_PR1,  B_D2,    OP_P_SET,       SH_0);
         10: u = mk_uop(A_ZERO, B_ZERO,  OP_ACC_SUB_TMP, SH_0);
         11: u = mk_uop(A_PLO,  B_RECIP, OP_TMP_SET,     SH_0);
         12: u = mk_uop(A_PHI,  B_RECIP, OP_TMP_ADD,     SH_32);
         13: u = mk_uop(A_ZERO, B_ZERO,  OP_ACC_SUB_TMP, SH_0);
         // acc times recip
         15: u = mk_uop(A_ACC0, B_RECIP, OP_T1_SET,      SH_0);
         16: u = mk_uop(A_ACC1, B_RECIP, OP_T1_ADD,      SH_32);
         17: u = mk_uop(A_ACC2, B_RECIP, OP_T1_ADD,      SH_64);
         // acc times rest*recip
         18: u = mk_uop(A_ACC0, B_KLO,   OP_TMP_SET,     SH_0);
         19: u = mk_uop(A_ACC1, B_KLO,   OP_TMP_ADD,     SH_32);
         20: u = mk_uop(A_ACC2, B_KLO,   OP_TMP_ADD,     SH_64);
         21: u = mk_uop(A_ACC0, B_KHI,   OP_TMP_ADD,     SH_32);
         22: u = mk_uop(A_ACC1, B_KHI,   OP_TMP_ADD,     SH_64);
         23: u = mk_uop(A_ACC2, B_KHI,   OP_TMP_ADD,     SH_96);
         24: u = mk_uop(A_ZERO, B_ZERO,  OP_T1_ADD_TMP,  SH_0);
         // rounding, saturation and new remainder
         25: u = mk_uop(A_ZERO, B_ZERO,  OP_RND_MAG,     SH_0);
         26: u = mk_uop(A_ZERO, B_ZERO,  OP_RND_SAT,     SH_0);
         28: u = mk_uop(A_Y,    B_D0,    OP_ACC_SUB,     SH_0);
         default: u = UOP_NOP;
      endcase
      return u;
   endfunction

endpackage

// ===== hdl/nbef_ctrl.sv =====
// step sequencer and handshake control for the notch biquad filter
`timescale 1ns / 1ps

module nbef_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output nbef_pkg::dp_cmd_type    cmd
);
   import nbef_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '{load: 1'b0, finish: 1'b0, uop: UOP_NOP};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.uop = ucode(step_ff);
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/nbef_datapath.sv =====
// registers, shared multiplier and accumulators of the notch biquad filter
`timescale 1ns / 1ps

module nbef_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  nbef_pkg::dp_cmd_type             cmd,
   input  logic [nbef_pkg::SAMPLE_W-1:0]    sample_in,
   input  logic                             csr_we,
   input  logic [nbef_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nbef_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [nbef_pkg::SAMPLE_W-1:0]    sample_out
);
   import nbef_pkg::*;

   localparam int RM_W = T1_W - FRAC_W;
   localparam logic [T1_W-1:0] RND_HALF = T1_W'(1) << (FRAC_W - 1);
   localparam logic [RM_W-1:0] NEG_LIM  = RM_W'(1) << (SAMPLE_W - 1);
   localparam logic [RM_W-1:0] POS_LIM  = NEG_LIM - 1'b1;
   localparam logic [SAMPLE_W-1:0] Y_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] Y_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [REM_W-1:0] REM_MIN  = {1'b1, {(REM_W-1){1'b0}}};
   localparam logic [REM_W-1:0] REM_MAX  = {1'b0, {(REM_W-1){1'b1}}};

   // configuration
   logic [COEFF_W-1:0] num_c0_ff, num_c0_in, num_c1_ff, num_c1_in;
   logic [COEFF_W-1:0] num_c2_ff, num_c2_in, den_c1_ff, den_c1_in;
   logic [COEFF_W-1:0] den_c2_ff, den_c2_in;
   logic [DEN0_W-1:0]  den_c0_ff, den_c0_in;
   logic [RECIP_W-1:0] recip_ff, recip_in;
   logic [REST_W-1:0]  rest_ff, rest_in;

   // history
   logic [SAMPLE_W-1:0] pi0_ff, pi0_in, pi1_ff, pi1_in;
   logic [SAMPLE_W-1:0] po0_ff, po0_in, po1_ff, po1_in;
   logic [REM_W-1:0]    pr0_ff, pr0_in, pr1_ff, pr1_in;

   // working registers
   logic [SAMPLE_W-1:0] x_ff, x_in, y_ff, y_in, out_ff, out_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   op_type              wop_ff;
   shift_type           wsh_ff;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [P_W-1:0]      p_ff, p_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic [TMP_W-1:0]    tmp_ff, tmp_in;
   logic [T1_W-1:0]     t1_ff, t1_in, mag_ff, mag_in;
   logic                neg_ff, neg_in;

   logic [MUL_W-1:0]    op_a, op_b;
   logic [TMP_W-1:0]    tmp_prod, tmp_sar;
   logic [RM_W-1:0]     rnd_m;
   logic [REM_W-1:0]    rem_sat;
   logic [ACC_W-REM_W:0] acc_top;
   logic                t1_neg;

   // control, configuration and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_c0_ff <= NUM_C0_RST;
         num_c1_ff <= '0;
         num_c2_ff <= '0;
         den_c0_ff <= DEN_C0_RST;
         den_c1_ff <= '0;
         den_c2_ff <= '0;
         recip_ff  <= RECIP_RST;
         rest_ff   <= '0;
         pi0_ff    <= '0;
         pi1_ff    <= '0;
         po0_ff    <= '0;
         po1_ff    <= '0;
         pr0_ff    <= '0;
         pr1_ff    <= '0;
         wop_ff    <= OP_NOP;
      end else begin
         num_c0_ff <= num_c0_in;
         num_c1_ff <= num_c1_in;
         num_c2_ff <= num_c2_in;
         den_c0_ff <= den_c0_in;
         den_c1_ff <= den_c1_in;
         den_c2_ff <= den_c2_in;
         recip_ff  <= recip_in;
         rest_ff   <= rest_in;
         pi0_ff    <= pi0_in;
         pi1_ff    <= pi1_in;
         po0_ff    <= po0_in;
         po1_ff    <= po1_in;
         pr0_ff    <= pr0_in;
         pr1_ff    <= pr1_in;
         wop_ff    <= cmd.uop.op;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      out_ff  <= out_in;
      prod_ff <= prod_in;
      wsh_ff  <= cmd.uop.shift;
      acc_ff  <= acc_in;
      p_ff    <= p_in;
      k_ff    <= k_in;
      tmp_ff  <= tmp_in;
      t1_ff   <= t1_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
   end

   // multiplier operand a
   always_comb begin
      unique case (cmd.uop.a_sel)
         A_ZERO: op_a = '0;
         A_X:    op_a = MUL_W'($signed(x_ff));
         A_PI0:  op_a = MUL_W'($signed(pi0_ff));
         A_PI1:  op_a = MUL_W'($signed(pi1_ff));
         A_PO0:  op_a = MUL_W'($signed(po0_ff));
         A_PO1:  op_a = MUL_W'($signed(po1_ff));
         A_PR0:  op_a = MUL_W'($signed(pr0_ff));
         A_PR1:  op_a = MUL_W'($signed(pr1_ff));
         A_PLO:  op_a = MUL_W'(p_ff[CHUNK_W-1:0]);
         A_PHI:  op_a = MUL_W'($signed(p_ff[P_W-1:CHUNK_W]));
         A_ACC0: op_a = MUL_W'(acc_ff[CHUNK_W-1:0]);
         A_ACC1: op_a = MUL_W'(acc_ff[2*CHUNK_W-1:CHUNK_W]);
         A_ACC2: op_a = MUL_W'($signed(acc_ff[ACC_W-1:2*CHUNK_W]));
         A_Y:    op_a = MUL_W'($signed(y_ff));
         A_REST: op_a = MUL_W'(rest_ff);
         default: op_a = '0;
      endcase
   end

   // multiplier operand b
   always_comb begin
      unique case (cmd.uop.b_sel)
         B_ZERO:  op_b = '0;
         B_C0:    op_b = MUL_W'($signed(num_c0_ff));
         B_C1:    op_b = MUL_W'($signed(num_c1_ff));
         B_C2:    op_b = MUL_W'($signed(num_c2_ff));
         B_D0:    op_b = MUL_W'(den_c0_ff);
         B_D1:    op_b = MUL_W'($signed(den_c1_ff));
         B_D2:    op_b = MUL_W'($signed(den_c2_ff));
         B_RECIP: op_b = MUL_W'(recip_ff);
         B_KLO:   op_b = MUL_W'(k_ff[CHUNK_W-1:0]);
         B_KHI:   op_b = MUL_W'(k_ff[K_W-1:CHUNK_W]);
         default: op_b = '0;
      endcase
   end

   // shared signed multiplier, registered
   assign prod_in = $signed(op_a) * $signed(op_b);

   // product placed at its chunk offset
   always_comb begin
      case (wsh_ff)
         SH_0:    tmp_prod = TMP_W'($signed(prod_ff));
         SH_32:   tmp_prod = TMP_W'($signed(prod_ff)) << CHUNK_W;
         SH_64:   tmp_prod = TMP_W'($signed(prod_ff)) << (2 * CHUNK_W);
         SH_96:   tmp_prod = TMP_W'($signed(prod_ff)) << (3 * CHUNK_W);
         default: tmp_prod = '0;
      endcase
   end

   // scaled value, rounded toward minus infinity
   assign tmp_sar = $signed(tmp_ff) >>> FRAC_W;
   assign t1_neg  = t1_ff[T1_W-1];
   assign rnd_m   = mag_ff[T1_W-1:FRAC_W];

   // new remainder saturated to 32 bits
   assign acc_top = acc_ff[ACC_W-1:REM_W-1];
   always_comb begin
      if ((&acc_top) || !(|acc_top)) begin
         rem_sat = acc_ff[REM_W-1:0];
      end else begin
         rem_sat = acc_ff[ACC_W-1] ? REM_MIN : REM_MAX;
      end
   end

   // next values
   always_comb begin
      num_c0_in = num_c0_ff;
      num_c1_in = num_c1_ff;
      num_c2_in = num_c2_ff;
      den_c0_in = den_c0_ff;
      den_c1_in = den_c1_ff;
      den_c2_in = den_c2_ff;
      recip_in  = recip_ff;
      rest_in   = rest_ff;
      pi0_in    = pi0_ff;
      pi1_in    = pi1_ff;
      po0_in    = po0_ff;
      po1_in    = po1_ff;
      pr0_in    = pr0_ff;
      pr1_in    = pr1_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      out_in    = out_ff;
      acc_in    = acc_ff;
      p_in      = p_ff;
      k_in      = k_ff;
      tmp_in    = tmp_ff;
      t1_in     = t1_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_C0:     num_c0_in = csr_data[COEFF_W-1:0];
            CSR_NUM_C1:     num_c1_in = csr_data[COEFF_W-1:0];
            CSR_NUM_C2:     num_c2_in = csr_data[COEFF_W-1:0];
            CSR_DEN_C0:     den_c0_in = csr_data[DEN0_W-1:0];
            CSR_DEN_C1:     den_c1_in = csr_data[COEFF_W-1:0];
            CSR_DEN_C2:     den_c2_in = csr_data[COEFF_W-1:0];
            CSR_RECIP_Q30:  recip_in  = csr_data[RECIP_W-1:0];
            CSR_RECIP_REST: rest_in   = csr_data[REST_W-1:0];
            default: ;
         endcase
      end

      // item capture
      if (cmd.load) begin
         x_in = sample_in;
      end

      // write stage of the previous step
      case (wop_ff)
         OP_ACC_SET:     acc_in = tmp_prod[ACC_W-1:0];
         OP_ACC_ADD:     acc_in = acc_ff + tmp_prod[ACC_W-1:0];
         OP_ACC_SUB:     acc_in = acc_ff - tmp_prod[ACC_W-1:0];
         OP_P_SET:       p_in   = prod_ff[P_W-1:0];
         OP_K_SET:       k_in   = prod_ff[K_W-1:0];
         OP_TMP_SET:     tmp_in = tmp_prod;
         OP_TMP_ADD:     tmp_in = tmp_ff + tmp_prod;
         OP_T1_SET:      t1_in  = tmp_prod[T1_W-1:0];
         OP_T1_ADD:      t1_in  = t1_ff + tmp_prod[T1_W-1:0];
         OP_ACC_SUB_TMP: acc_in = acc_ff - tmp_sar[ACC_W-1:0];
         OP_T1_ADD_TMP:  t1_in  = t1_ff + tmp_sar[T1_W-1:0];
         OP_RND_MAG: begin
            // magnitude plus half an lsb of the integer part
            neg_in = t1_neg;
            mag_in = (t1_neg ? ~t1_ff : t1_ff) + RND_HALF + T1_W'(t1_neg);
         end
         OP_RND_SAT: begin
            if (neg_ff) begin
               y_in = (rnd_m > NEG_LIM) ? Y_MIN : SAMPLE_W'(0) - rnd_m[SAMPLE_W-1:0];
            end else begin
               y_in = (rnd_m > POS_LIM) ? Y_MAX : rnd_m[SAMPLE_W-1:0];
            end
         end
         default: ;
      endcase

      // history shift and result load
      if (cmd.finish) begin
         pi1_in = pi0_ff;
         pi0_in = x_ff;
         po1_in = po0_ff;
         po0_in = y_ff;
         pr1_in = pr0_ff;
         pr0_in = rem_sat;
         out_in = y_ff;
      end
   end

   assign sample_out = out_ff;

endmodule

// ===== hdl/notch_biquad_error_feedback.sv =====
// top level of the notch biquad filter with truncation error feedback
// an accepted item runs the 30-step sequence on the single shared 33x33
//   multiplier and then a finish state, and input stalls until it is done
// a pending result waits in the output register while the next item runs
// reset: synchronous, clears history to zero and loads unity pass-through
`timescale 1ns / 1ps

module notch_biquad_error_feedback (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [nbef_pkg::SAMPLE_W-1:0]    req_sample_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [nbef_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nbef_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nbef_pkg::CSR_DATA_W-1:0]  csr_data
);
   import nbef_pkg::*;

   dp_cmd_type cmd;
   logic       csr_we;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   nbef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   nbef_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample_in  (req_sample_in),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .sample_out (rsp_sample_out)
   );

endmodule

// ===== hdl/nbef_checker.sv =====
// port-level assertions for the notch biquad filter and their bind
`timescale 1ns / 1ps

module nbef_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_sample_out
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed or dropped");

   // an accepted item keeps the block busy and stalls further input
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall ##1 req_stall)
      else $error("input taken again too soon after an item");

   // a new result only comes out of work in progress
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in flight");

   // reset leaves the block empty and ready
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

bind notch_biquad_error_feedback nbef_checker u_nbef_checker (.*);
